// ----- sv/rar_pkg.sv -----
// ----------------------------------------------------------------------------
// rar_pkg
// Shared widths, opcodes, transaction structs and sequencer states for the
// rational arithmetic unit.
// ----------------------------------------------------------------------------
package rar_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_W        = 2 * OPERAND_WIDTH;
   localparam int MAG_W         = PROD_W + 1;
   localparam int SUB_W         = MAG_W + 1;
   localparam int CNT_W         = $clog2(MAG_W);
   localparam int RES_NUM_W     = 33;
   localparam int RES_DEN_W     = 31;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MAG_W - 1);

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef struct packed {
      op_type                          opcode;
      logic signed [OPERAND_WIDTH-1:0] a_num;
      logic signed [OPERAND_WIDTH-1:0] a_den;
      logic signed [OPERAND_WIDTH-1:0] b_num;
      logic signed [OPERAND_WIDTH-1:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [RES_NUM_W-1:0] res_num;
      logic [RES_DEN_W-1:0]        res_den;
      logic                        div_zero;
   } rsp_type;

   typedef struct packed {
      logic             ge;
      logic [SUB_W-1:0] diff;
   } sub_res_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_A,
      S_MUL_B,
      S_MUL_C,
      S_MUL_D,
      S_CHECK,
      S_GCD,
      S_DIV_N,
      S_DIV_D,
      S_DONE
   } state_type;

endpackage

// ----- sv/rational_alu_reduce.sv -----
// ----------------------------------------------------------------------------
// rational_alu_reduce
// Adds, subtracts, multiplies or divides two signed fractions and reduces the
// result by the gcd of numerator and denominator magnitudes.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------
//   req     | in        | req_valid / req_ready | req_data (rar_pkg::req_type)
//   rsp     | out       | rsp_valid / rsp_ready | rsp_data (rar_pkg::rsp_type)
//
// A zero numerator or denominator skips the gcd and divisions after the check
// state; otherwise three products go through the one multiplier, then binary
// gcd steps (one shift, one subtract and halve, or one swap per cycle), then
// two restoring divisions by the gcd through the shared subtract unit, each
// of MAG_W quotient bits (MAG_W = 33 here), one quotient bit a cycle. Reset
// clears the sequencer and the output valid.
// req_ready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next transaction may start meanwhile.
// ----------------------------------------------------------------------------
module rational_alu_reduce (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rar_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rar_pkg::rsp_type rsp_data
);
   import rar_pkg::*;

   localparam int NUM_XW = MAG_W + RES_NUM_W;
   localparam int DEN_XW = MAG_W + RES_DEN_W;

   // sequencer
   state_type state_ff, state_in;

   // operands of the current transaction
   op_type                          op_ff;
   logic signed [OPERAND_WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;

   // unreduced values, two's complement held as plain bits
   logic [MAG_W-1:0] n_ff, n_in;
   logic [MAG_W-1:0] d_ff, d_in;

   // magnitudes, which become the quotients during division
   logic [MAG_W-1:0] nm_ff, nm_in;
   logic [MAG_W-1:0] dm_ff, dm_in;

   // gcd working pair, common power of two, gcd, division remainder
   logic [MAG_W-1:0] u_ff, u_in;
   logic [MAG_W-1:0] v_ff, v_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [MAG_W-1:0] g_ff, g_in;
   logic [MAG_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;

   // staged result (numerator as magnitude) and output register
   rsp_type res_ff, res_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // shared units
   logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
   logic [PROD_W-1:0]               prod;
   logic [MAG_W-1:0]                prod_ext;
   logic [SUB_W-1:0]                sub_a, sub_b;
   sub_res_type                     sub_res;

   logic             req_fire;
   logic             out_free;
   logic             gcd_end;
   logic             div_msb;
   logic [SUB_W-1:0] div_t;
   logic [MAG_W-1:0] quo_next;
   logic [MAG_W-1:0] rem_next;
   logic [MAG_W-1:0] n_mag, d_mag;
   logic [NUM_XW-1:0] num_ext;
   logic [DEN_XW-1:0] den_ext;

   rar_mult u_mult (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   rar_sub u_sub (
      .op_a (sub_a),
      .op_b (sub_b),
      .res  (sub_res)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign gcd_end   = (u_ff == '0) | (v_ff == '0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign prod_ext = {prod[PROD_W-1], prod};
   assign n_mag    = n_ff[MAG_W-1] ? (MAG_W'(0) - n_ff) : n_ff;
   assign d_mag    = d_ff[MAG_W-1] ? (MAG_W'(0) - d_ff) : d_ff;

   // one restoring division step: bring down the next dividend bit
   assign div_t    = {r_ff, div_msb};
   assign quo_next = (state_ff == S_DIV_N) ? {nm_ff[MAG_W-2:0], sub_res.ge}
                                           : {dm_ff[MAG_W-2:0], sub_res.ge};
   assign rem_next = sub_res.ge ? sub_res.diff[MAG_W-1:0] : div_t[MAG_W-1:0];
   assign num_ext  = {{RES_NUM_W{1'b0}}, quo_next};
   assign den_ext  = {{RES_DEN_W{1'b0}}, quo_next};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_MUL_A;
         end
         S_MUL_A: state_in = S_MUL_B;
         S_MUL_B: state_in = S_MUL_C;
         S_MUL_C: state_in = S_MUL_D;
         S_MUL_D: state_in = S_CHECK;
         S_CHECK: begin
            if ((d_ff == '0) || (n_ff == '0)) state_in = S_DONE;
            else                              state_in = S_GCD;
         end
         S_GCD: begin
            if (gcd_end) state_in = S_DIV_N;
         end
         S_DIV_N: begin
            if (cnt_ff == LAST_STEP) state_in = S_DIV_D;
         end
         S_DIV_D: begin
            if (cnt_ff == LAST_STEP) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // shared unit operand selection
   always_comb begin
      mul_a   = an_ff;
      mul_b   = bd_ff;
      sub_a   = {1'b0, u_ff};
      sub_b   = {1'b0, v_ff};
      div_msb = nm_ff[MAG_W-1];
      unique case (state_ff)
         S_MUL_A: begin
            mul_a = an_ff;
            mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         S_MUL_B: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         S_MUL_C: begin
            mul_a = ad_ff;
            mul_b = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         S_DIV_N: begin
            div_msb = nm_ff[MAG_W-1];
            sub_a   = div_t;
            sub_b   = {1'b0, g_ff};
         end
         S_DIV_D: begin
            div_msb = dm_ff[MAG_W-1];
            sub_a   = div_t;
            sub_b   = {1'b0, g_ff};
         end
         default: begin
            sub_a = {1'b0, u_ff};
            sub_b = {1'b0, v_ff};
         end
      endcase
   end

   // datapath next values
   always_comb begin
      n_in         = n_ff;
      d_in         = d_ff;
      nm_in        = nm_ff;
      dm_in        = dm_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      k_in         = k_ff;
      g_in         = g_ff;
      r_in         = r_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_MUL_B: n_in = prod_ext;
         S_MUL_C: begin
            // fold in the cross term for add and subtract only
            if (op_ff == OP_ADD)      n_in = n_ff + prod_ext;
            else if (op_ff == OP_SUB) n_in = n_ff - prod_ext;
         end
         S_MUL_D: d_in = prod_ext;
         S_CHECK: begin
            nm_in  = n_mag;
            dm_in  = d_mag;
            u_in   = n_mag;
            v_in   = d_mag;
            k_in   = '0;
            neg_in = n_ff[MAG_W-1] ^ d_ff[MAG_W-1];
            if (d_ff == '0) begin
               neg_in          = 1'b0;
               res_in.res_num  = '0;
               res_in.res_den  = '0;
               res_in.div_zero = 1'b1;
            end else if (n_ff == '0) begin
               neg_in          = 1'b0;
               res_in.res_num  = '0;
               res_in.res_den  = RES_DEN_W'(1);
               res_in.div_zero = 1'b0;
            end
         end
         S_GCD: begin
            priority if (gcd_end) begin
               g_in   = (u_ff | v_ff) << k_ff;
               r_in   = '0;
               cnt_in = '0;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + CNT_W'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (sub_res.ge) begin
               u_in = sub_res.diff[MAG_W:1];
            end else begin
               // keep the larger value in u for the next subtract
               u_in = v_ff;
               v_in = u_ff;
            end
         end
         S_DIV_N: begin
            nm_in  = quo_next;
            r_in   = rem_next;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               res_in.res_num = num_ext[RES_NUM_W-1:0];
               r_in           = '0;
               cnt_in         = '0;
            end
         end
         S_DIV_D: begin
            dm_in  = quo_next;
            r_in   = rem_next;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               res_in.res_den  = den_ext[RES_DEN_W-1:0];
               res_in.div_zero = 1'b0;
            end
         end
         S_DONE: begin
            if (out_free) begin
               // apply the sign on the way out
               rsp_data_in         = res_ff;
               rsp_data_in.res_num = neg_ff ? (RES_NUM_W'(0) - res_ff.res_num)
                                            : res_ff.res_num;
               rsp_valid_in        = 1'b1;
            end
         end
         default: begin
            n_in = n_ff;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // capture operands on acceptance
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_data.opcode;
         an_ff <= req_data.a_num;
         ad_ff <= req_data.a_den;
         bn_ff <= req_data.b_num;
         bd_ff <= req_data.b_den;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      d_ff        <= d_in;
      nm_ff       <= nm_in;
      dm_ff       <= dm_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      k_ff        <= k_in;
      g_ff        <= g_in;
      r_ff        <= r_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- sv/rar_mult.sv -----
// ----------------------------------------------------------------------------
// rar_mult
// Signed operand multiplier with a registered product.
// ----------------------------------------------------------------------------
module rar_mult (
   input  logic                                    clock,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] op_a,
   input  logic signed [rar_pkg::OPERAND_WIDTH-1:0] op_b,
   output logic [rar_pkg::PROD_W-1:0]               prod
);
   import rar_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = op_a * op_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- sv/rar_sub.sv -----
// ----------------------------------------------------------------------------
// rar_sub
// Shared compare and subtract unit for the gcd and division steps.
// ----------------------------------------------------------------------------
module rar_sub (
   input  logic [rar_pkg::SUB_W-1:0] op_a,
   input  logic [rar_pkg::SUB_W-1:0] op_b,
   output rar_pkg::sub_res_type      res
);
   import rar_pkg::*;

   logic [SUB_W:0] full;

   assign full     = {1'b0, op_a} - {1'b0, op_b};
   assign res.diff = full[SUB_W-1:0];
   assign res.ge   = ~full[SUB_W];

endmodule
